[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CHSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("chss assertion failed");

// Condition must never be true at a clock edge outside reset.
`define CHSS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("chss forbidden condition seen");

`else

`define CHSS_ASSERT(label, clk, rst, prop)

`define CHSS_NEVER(label, clk, rst, cond)

`endif

`endif

[hw/rtl/chss_pkg.sv]
`timescale 1ns / 1ps

package chss_pkg;

   localparam int PIX_BITS           = 8;
   localparam int CFG_WIDTH_BITS     = 12;
   localparam int CFG_HEIGHT_BITS    = 13;
   localparam int CSR_DATA_BITS      = 13;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam logic [CFG_WIDTH_BITS-1:0]  RESET_IMAGE_WIDTH  = 12'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] RESET_IMAGE_HEIGHT = 13'd480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Raster position of the pixel being accepted.
   typedef struct packed {
      logic odd_row;
      logic last_row;
      logic frame_end;
   } pos_type;

endpackage

[hw/rtl/chss_ctrl.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chss_ctrl #(
   parameter int MAX_WIDTH  = chss_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = chss_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [chss_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [chss_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                    advance,
   output logic [$clog2(MAX_WIDTH)-1:0]            col_idx,
   output chss_pkg::pos_type                       pos
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WCMP = (chss_pkg::CFG_WIDTH_BITS > CW + 1) ?
                         chss_pkg::CFG_WIDTH_BITS : CW + 1;
   localparam int HCMP = (chss_pkg::CFG_HEIGHT_BITS > RW + 1) ?
                         chss_pkg::CFG_HEIGHT_BITS : RW + 1;
   localparam logic [WCMP-1:0] MAX_W_EXT = WCMP'(MAX_WIDTH);
   localparam logic [HCMP-1:0] MAX_H_EXT = HCMP'(MAX_HEIGHT);

   logic [chss_pkg::CFG_WIDTH_BITS-1:0]  image_width_ff, image_width_in;
   logic [chss_pkg::CFG_HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic [CW-1:0]                        col_count_ff, col_count_in;
   logic [RW-1:0]                        row_count_ff, row_count_in;
   logic [WCMP-1:0]                      width_ext;
   logic [HCMP-1:0]                      height_ext;
   logic [CW-1:0]                        last_col_idx;
   logic [RW-1:0]                        last_row_idx;
   logic                                 last_col;
   logic                                 last_row;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (chss_pkg::csr_index_type'(csr_index))
            chss_pkg::REG_IMAGE_WIDTH: begin
               image_width_in = csr_wdata[chss_pkg::CFG_WIDTH_BITS-1:0];
            end
            chss_pkg::REG_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata[chss_pkg::CFG_HEIGHT_BITS-1:0];
            end
            default: begin
               image_width_in = image_width_ff;
            end
         endcase
      end
   end

   // Out-of-range sizes are clamped to one and to the buffer limits.
   always_comb begin
      width_ext  = WCMP'(image_width_ff);
      height_ext = HCMP'(image_height_ff);
      if (width_ext == '0) begin
         last_col_idx = '0;
      end else if (width_ext > MAX_W_EXT) begin
         last_col_idx = CW'(MAX_WIDTH - 1);
      end else begin
         last_col_idx = CW'(width_ext - WCMP'(1));
      end
      if (height_ext == '0) begin
         last_row_idx = '0;
      end else if (height_ext > MAX_H_EXT) begin
         last_row_idx = RW'(MAX_HEIGHT - 1);
      end else begin
         last_row_idx = RW'(height_ext - HCMP'(1));
      end
   end

   assign last_col = col_count_ff >= last_col_idx;
   assign last_row = row_count_ff >= last_row_idx;
   assign col_idx  = (col_count_ff > last_col_idx) ? last_col_idx : col_count_ff;

   assign pos.odd_row   = row_count_ff[0];
   assign pos.last_row  = last_row;
   assign pos.frame_end = last_col & last_row;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (advance) begin
         if (last_col) begin
            col_count_in = '0;
            row_count_in = last_row ? '0 : row_count_ff + RW'(1);
         end else begin
            col_count_in = col_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= chss_pkg::RESET_IMAGE_WIDTH;
         image_height_ff <= chss_pkg::RESET_IMAGE_HEIGHT;
         col_count_ff    <= '0;
         row_count_ff    <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_count_ff    <= col_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   `CHSS_ASSERT(a_frame_wraps, clock, reset, (advance && pos.frame_end) |=> (col_count_ff == '0 && row_count_ff == '0))
   `CHSS_ASSERT(a_col_held, clock, reset, (!advance && !csr_we) |=> $stable(col_idx))

endmodule

[hw/rtl/chss_line_buf.sv]
`timescale 1ns / 1ps

module chss_line_buf #(
   parameter int DEPTH = chss_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [2*chss_pkg::PIX_BITS-1:0]   wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [2*chss_pkg::PIX_BITS-1:0]   rd_data
);

   logic [2*chss_pkg::PIX_BITS-1:0] mem_ff [DEPTH];
   logic [2*chss_pkg::PIX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/chroma_subsample_440_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  luma, chroma b, chroma r
// rsp       out        rsp_valid / rsp_ready  luma, chroma valid, chroma b, r, frame end
// csr       in         csr_we                 csr_index, csr_wdata
//
// One pixel per clock while the output is not stalled; each accepted beat is registered
// in the read stage and then in the response register. The rate is set by the line
// buffer's single access per pixel: write on even rows, read on odd rows. Reset
// clears counters and restores default sizes; the line buffer needs no clearing. A
// stalled output holds the read stage, which then stops accepting input.

`include "assert_macros.svh"

module chroma_subsample_440_top #(
   parameter int MAX_WIDTH  = chss_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = chss_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [chss_pkg::PIX_BITS-1:0]        req_luma_in,
   input  logic [chss_pkg::PIX_BITS-1:0]        req_chroma_b_in,
   input  logic [chss_pkg::PIX_BITS-1:0]        req_chroma_r_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [chss_pkg::PIX_BITS-1:0]        rsp_luma_out,
   output logic                                 rsp_chroma_valid,
   output logic [chss_pkg::PIX_BITS-1:0]        rsp_chroma_b_out,
   output logic [chss_pkg::PIX_BITS-1:0]        rsp_chroma_r_out,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_we,
   input  logic [chss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [chss_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int PB = chss_pkg::PIX_BITS;
   localparam int CW = $clog2(MAX_WIDTH);

   logic              accept;
   logic              out_free;
   logic [CW-1:0]     col_idx;
   chss_pkg::pos_type pos;
   logic [2*PB-1:0]   line_rd_data;

   logic              s1_valid_ff, s1_valid_in;
   logic [PB-1:0]     s1_luma_ff;
   logic [PB-1:0]     s1_cb_ff;
   logic [PB-1:0]     s1_cr_ff;
   chss_pkg::pos_type s1_pos_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0]     rsp_luma_ff;
   logic              rsp_cvalid_ff, rsp_cvalid_in;
   logic [PB-1:0]     rsp_cb_ff, rsp_cb_in;
   logic [PB-1:0]     rsp_cr_ff, rsp_cr_in;
   logic              rsp_fend_ff;
   logic [PB:0]       sum_b;
   logic [PB:0]       sum_r;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   chss_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .col_idx   (col_idx),
      .pos       (pos)
   );

   chss_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && !pos.odd_row),
      .wr_addr (col_idx),
      .wr_data ({req_chroma_b_in, req_chroma_r_in}),
      .rd_en   (accept && pos.odd_row),
      .rd_addr (col_idx),
      .rd_data (line_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      sum_b = {1'b0, line_rd_data[2*PB-1:PB]} + {1'b0, s1_cb_ff};
      sum_r = {1'b0, line_rd_data[PB-1:0]} + {1'b0, s1_cr_ff};
      if (s1_pos_ff.odd_row) begin
         rsp_cvalid_in = 1'b1;
         rsp_cb_in     = sum_b[PB:1];
         rsp_cr_in     = sum_r[PB:1];
      end else if (s1_pos_ff.last_row) begin
         rsp_cvalid_in = 1'b1;
         rsp_cb_in     = s1_cb_ff;
         rsp_cr_in     = s1_cr_ff;
      end else begin
         rsp_cvalid_in = 1'b0;
         rsp_cb_in     = '0;
         rsp_cr_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_ff <= req_luma_in;
         s1_cb_ff   <= req_chroma_b_in;
         s1_cr_ff   <= req_chroma_r_in;
         s1_pos_ff  <= pos;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_luma_ff   <= s1_luma_ff;
         rsp_cvalid_ff <= rsp_cvalid_in;
         rsp_cb_ff     <= rsp_cb_in;
         rsp_cr_ff     <= rsp_cr_in;
         rsp_fend_ff   <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma_out     = rsp_luma_ff;
   assign rsp_chroma_valid = rsp_cvalid_ff;
   assign rsp_chroma_b_out = rsp_cb_ff;
   assign rsp_chroma_r_out = rsp_cr_ff;
   assign rsp_frame_end    = rsp_fend_ff;

   `CHSS_ASSERT(a_s1_holds, clock, reset, (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_luma_ff) && $stable(line_rd_data)))
   `CHSS_ASSERT(a_no_chroma_zero, clock, reset, (rsp_valid && !rsp_chroma_valid) |-> (rsp_chroma_b_out == '0 && rsp_chroma_r_out == '0))
   `CHSS_ASSERT(a_fend_has_chroma, clock, reset, (rsp_valid && rsp_frame_end) |-> rsp_chroma_valid)
   `CHSS_NEVER(a_no_accept_full, clock, reset, accept && s1_valid_ff && !out_free)

endmodule
